FILE: src/itpt_pkg.sv
// Shared types, codes and character helpers for the integer-to-text unit.
package itpt_pkg;

  // Radix codes as they arrive on the input; code 3 is folded into hexadecimal.
  typedef enum logic [1:0] {
    RADIX_OCT = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  // Bit positions inside the flag field.
  localparam int BIT_LEFT  = 0;
  localparam int BIT_PLUS  = 1;
  localparam int BIT_SPACE = 2;
  localparam int BIT_ALT   = 3;
  localparam int BIT_ZERO  = 4;
  localparam int BIT_UPPER = 5;

  // ASCII codes used by the formatter.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_A_LO  = 8'h61;

  // Classified item as it travels from the front end to the back end.
  typedef struct packed {
    logic       neg;
    radix_t     radix;
    logic [6:0] width;
    logic       prec_given;
    logic [5:0] prec;
    logic       left;
    logic       plus;
    logic       space;
    logic       alt;
    logic       zero;
    logic       upper;
    logic       mag_zero;
  } item_desc_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_COUNT,
    BK_PLAN,
    BK_EMIT
  } back_state_t;

  // Map one digit value to its ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = (upper ? CH_A_UP : CH_A_LO) + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

FILE: src/integer_to_padded_text_unit.sv
// Top level of the printf-style integer to text unit.
//
// An item is taken when start is high and busy is low; busy rises only while the two-entry
// queue between the front and back ends is full. Each character of the text leaves on
// out_char_out for one cycle with out_strobe high, and out_is_last marks the final one; the
// receiver must take every character as it comes. Decimal items pass through the back end's
// conversion step before the character sequencer, which octal and hexadecimal items skip:
// the decimal digits come from a shift-and-add-3 converter that consumes two value bits per
// cycle, and the character sequencer sends one character per cycle. A zero value with zero
// precision, no prefix and no field width yields no characters and no strobe at all. There
// are no configuration registers.
module integer_to_padded_text_unit #(
  parameter int MAX_CHARS  = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_magnitude,
  input  logic        in_is_negative,
  input  logic [1:0]  in_radix,
  input  logic [6:0]  in_field_width,
  input  logic [6:0]  in_min_digits,
  input  logic [5:0]  in_flag_bits,
  output logic        out_strobe,
  output logic [7:0]  out_char_out,
  output logic        out_is_last
);
  import itpt_pkg::*;

  localparam int DESC_W  = $bits(item_desc_t);
  localparam int QUEUE_W = DESC_W + VALUE_BITS;

  logic                  push;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  item_desc_t            f_desc;
  logic [VALUE_BITS-1:0] f_mag;
  logic [QUEUE_W-1:0]    q_rdata;
  item_desc_t            q_desc;
  logic [VALUE_BITS-1:0] q_mag;

  itpt_front #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_CHARS (MAX_CHARS)
  ) u_front (
    .start          (start),
    .busy           (busy),
    .in_magnitude   (in_magnitude),
    .in_is_negative (in_is_negative),
    .in_radix       (in_radix),
    .in_field_width (in_field_width),
    .in_min_digits  (in_min_digits),
    .in_flag_bits   (in_flag_bits),
    .q_full         (q_full),
    .push           (push),
    .desc           (f_desc),
    .mag            (f_mag)
  );

  itpt_queue #(
    .WIDTH(QUEUE_W),
    .DEPTH(2)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({f_desc, f_mag}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_desc = q_rdata[QUEUE_W-1:VALUE_BITS];
  assign q_mag  = q_rdata[VALUE_BITS-1:0];

  itpt_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_desc       (q_desc),
    .q_mag        (q_mag),
    .q_pop        (q_pop),
    .out_strobe   (out_strobe),
    .out_char_out (out_char_out),
    .out_is_last  (out_is_last)
  );

endmodule

FILE: src/itpt_front.sv
// Front end: accepts items and classifies radix, width, precision and flags.
module itpt_front #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_CHARS  = 64
) (
  input  logic                   start,
  output logic                   busy,
  input  logic [63:0]            in_magnitude,
  input  logic                   in_is_negative,
  input  logic [1:0]             in_radix,
  input  logic [6:0]             in_field_width,
  input  logic [6:0]             in_min_digits,
  input  logic [5:0]             in_flag_bits,
  input  logic                   q_full,
  output logic                   push,
  output itpt_pkg::item_desc_t   desc,
  output logic [VALUE_BITS-1:0]  mag
);
  import itpt_pkg::*;

  localparam logic [6:0] WIDTH_MAX = 7'(MAX_CHARS);
  localparam logic [5:0] PREC_MAX  = 6'(MAX_CHARS - 4);

  // Handshake: an item enters whenever the queue has room.
  assign busy = q_full;
  assign push = start && !q_full;

  assign mag = in_magnitude[VALUE_BITS-1:0];

  // Classification of the item.
  always_comb begin
    desc.neg = in_is_negative;
    if (in_radix == RADIX_OCT) begin
      desc.radix = RADIX_OCT;
    end else if (in_radix == RADIX_DEC) begin
      desc.radix = RADIX_DEC;
    end else begin
      desc.radix = RADIX_HEX;
    end
    desc.width      = (in_field_width > WIDTH_MAX) ? WIDTH_MAX : in_field_width;
    desc.prec_given = !in_min_digits[6];
    desc.prec       = (in_min_digits[5:0] > PREC_MAX) ? PREC_MAX : in_min_digits[5:0];
    desc.left       = in_flag_bits[BIT_LEFT];
    desc.plus       = in_flag_bits[BIT_PLUS];
    desc.space      = in_flag_bits[BIT_SPACE];
    desc.alt        = in_flag_bits[BIT_ALT];
    // An explicit precision or left justification cancels zero padding.
    desc.zero       = in_flag_bits[BIT_ZERO] && in_min_digits[6] && !in_flag_bits[BIT_LEFT];
    desc.upper      = in_flag_bits[BIT_UPPER];
    desc.mag_zero   = ~|mag;
  end

endmodule

FILE: src/itpt_queue.sv
// Short first-in first-out queue between the front end and the back end.
module itpt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_FULL) |-> !push)
    else $error("item pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("item popped from an empty queue");

endmodule

FILE: src/itpt_back.sv
// Back end: digit conversion, layout planning and the character sequencer.
module itpt_back #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_CHARS  = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  itpt_pkg::item_desc_t  q_desc,
  input  logic [VALUE_BITS-1:0] q_mag,
  output logic                  q_pop,
  output logic                  out_strobe,
  output logic [7:0]            out_char_out,
  output logic                  out_is_last
);
  import itpt_pkg::*;

  // Octal needs the most digits of any radix.
  localparam int ND    = (VALUE_BITS + 2) / 3;
  localparam int DW    = 4 * ND;
  localparam int NW    = $clog2(ND + 1);
  localparam int IW    = $clog2(ND);
  localparam int STEPS = (VALUE_BITS + 1) / 2;
  localparam int EVB   = 2 * STEPS;
  localparam int SW    = $clog2(STEPS + 1);
  localparam logic [SW-1:0] STEP_LAST = SW'(STEPS - 1);
  localparam logic [6:0]    CHAR_MAX  = 7'(MAX_CHARS);

  back_state_t state_r, state_nxt;
  item_desc_t  desc_r;
  logic [EVB-1:0] shift_r;
  logic [SW-1:0]  step_r;
  logic [DW-1:0]  dig_r;
  logic [NW-1:0]  n_r;
  logic [6:0]     zeroes_r;
  logic [7:0]     pre0_r, pre1_r;
  logic [6:0]     b1_r, b2_r, b3_r, b4_r;
  logic [6:0]     total_r;
  logic [6:0]     pos_r;
  logic           out_strobe_r;
  logic [7:0]     out_char_r;
  logic           out_last_r;

  logic           load_en, conv_en, count_en, plan_en, emit_en;
  logic [DW-1:0]  direct_dig;
  logic [DW-1:0]  dabble_dig;
  logic [NW-1:0]  n_calc;
  logic [6:0]     zeroes_calc;
  logic [7:0]     pre0_calc, pre1_calc;
  logic [6:0]     b1_calc, b2_calc, b3_calc, b4_calc, cnt_calc;
  logic           plan_empty;
  logic [7:0]     char_calc;
  logic           last_calc;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_desc.radix == RADIX_DEC) ? BK_CONV : BK_COUNT;
        end
      end
      BK_CONV: begin
        if (step_r == STEP_LAST) begin
          state_nxt = BK_COUNT;
        end
      end
      BK_COUNT: state_nxt = BK_PLAN;
      BK_PLAN: begin
        state_nxt = plan_empty ? BK_IDLE : BK_EMIT;
      end
      BK_EMIT: begin
        if (last_calc) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    load_en  = 1'b0;
    conv_en  = 1'b0;
    count_en = 1'b0;
    plan_en  = 1'b0;
    emit_en  = 1'b0;
    unique case (state_r)
      BK_IDLE:  load_en  = !q_empty;
      BK_CONV:  conv_en  = 1'b1;
      BK_COUNT: count_en = 1'b1;
      BK_PLAN:  plan_en  = 1'b1;
      BK_EMIT:  emit_en  = 1'b1;
      default:  load_en  = 1'b0;
    endcase
  end

  assign q_pop = load_en;

  // Octal and hexadecimal digits are plain bit slices of the value.
  always_comb begin
    logic [3*ND-1:0] mag3;
    logic [DW-1:0]   mag4;
    mag3 = (3 * ND)'(q_mag);
    mag4 = DW'(q_mag);
    direct_dig = '0;
    for (int i = 0; i < ND; i++) begin
      if (q_desc.radix == RADIX_OCT) begin
        direct_dig[4*i +: 4] = {1'b0, mag3[3*i +: 3]};
      end else begin
        direct_dig[4*i +: 4] = mag4[4*i +: 4];
      end
    end
  end

  // Two shift-and-add-3 steps of binary to decimal conversion per cycle.
  always_comb begin
    logic [DW-1:0] bcd;
    bcd = dig_r;
    for (int j = 0; j < 2; j++) begin
      for (int i = 0; i < ND; i++) begin
        if (bcd[4*i +: 4] >= 4'd5) begin
          bcd[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
        end
      end
      bcd = {bcd[DW-2:0], shift_r[EVB-1-j]};
    end
    dabble_dig = bcd;
  end

  // Digit count and precision zeros.
  always_comb begin
    logic [NW-1:0] top;
    top = '0;
    for (int i = 0; i < ND; i++) begin
      if (dig_r[4*i +: 4] != 4'd0) begin
        top = NW'(i + 1);
      end
    end
    if (top != '0) begin
      n_calc = top;
    end else begin
      // A zero value with zero precision prints no digits.
      n_calc = (desc_r.prec_given && desc_r.prec == 6'd0) ? '0 : NW'(1);
    end
    if (desc_r.prec_given && ({1'b0, desc_r.prec} > 7'(n_calc))) begin
      zeroes_calc = {1'b0, desc_r.prec} - 7'(n_calc);
    end else begin
      zeroes_calc = '0;
    end
  end

  // Prefix and segment boundaries of the text.
  always_comb begin
    logic [1:0] plen;
    logic [6:0] total;
    logic [6:0] pad;
    logic [6:0] zeroes;
    logic [6:0] trail;
    logic [6:0] sum;
    plen      = 2'd0;
    pre0_calc = CH_ZERO;
    pre1_calc = CH_X_LO;
    case (desc_r.radix)
      RADIX_DEC: begin
        if (desc_r.neg) begin
          plen = 2'd1;
          pre0_calc = CH_MINUS;
        end else if (desc_r.plus) begin
          plen = 2'd1;
          pre0_calc = CH_PLUS;
        end else if (desc_r.space) begin
          plen = 2'd1;
          pre0_calc = CH_SPACE;
        end
      end
      RADIX_OCT: begin
        // The octal marker is dropped when precision zeros or the lone digit of a zero value already lead.
        if (desc_r.alt && zeroes_r == '0 && !(desc_r.mag_zero && n_r != '0)) begin
          plen = 2'd1;
        end
      end
      default: begin
        if (desc_r.alt && !desc_r.mag_zero) begin
          plen = 2'd2;
          pre1_calc = desc_r.upper ? CH_X_UP : CH_X_LO;
        end
      end
    endcase
    total  = 7'(plen) + zeroes_r + 7'(n_r);
    pad    = (desc_r.width > total) ? desc_r.width - total : '0;
    zeroes = zeroes_r;
    if (desc_r.zero) begin
      zeroes = zeroes_r + pad;
      pad    = '0;
    end
    trail      = desc_r.left ? pad : '0;
    b1_calc    = desc_r.left ? '0 : pad;
    b2_calc    = b1_calc + 7'(plen);
    b3_calc    = b2_calc + zeroes;
    b4_calc    = b3_calc + 7'(n_r);
    sum        = b4_calc + trail;
    cnt_calc   = (sum > CHAR_MAX) ? CHAR_MAX : sum;
    plan_empty = (cnt_calc == '0);
  end

  // Character at the current output position.
  always_comb begin
    logic [3:0]    dig_a [ND];
    logic [6:0]    idx;
    for (int i = 0; i < ND; i++) begin
      dig_a[i] = dig_r[4*i +: 4];
    end
    idx = b4_r - 7'd1 - pos_r;
    if (pos_r < b1_r) begin
      char_calc = CH_SPACE;
    end else if (pos_r < b2_r) begin
      char_calc = (pos_r == b1_r) ? pre0_r : pre1_r;
    end else if (pos_r < b3_r) begin
      char_calc = CH_ZERO;
    end else if (pos_r < b4_r) begin
      char_calc = digit_char(dig_a[idx[IW-1:0]], desc_r.upper);
    end else begin
      char_calc = CH_SPACE;
    end
    last_calc = (pos_r == total_r - 7'd1);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= emit_en;
      out_last_r   <= emit_en && last_calc;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (load_en) begin
      desc_r  <= q_desc;
      shift_r <= EVB'(q_mag);
      step_r  <= '0;
      dig_r   <= (q_desc.radix == RADIX_DEC) ? '0 : direct_dig;
    end
    if (conv_en) begin
      dig_r   <= dabble_dig;
      shift_r <= {shift_r[EVB-3:0], 2'b00};
      step_r  <= step_r + 1'b1;
    end
    if (count_en) begin
      n_r      <= n_calc;
      zeroes_r <= zeroes_calc;
    end
    if (plan_en) begin
      pre0_r  <= pre0_calc;
      pre1_r  <= pre1_calc;
      b1_r    <= b1_calc;
      b2_r    <= b2_calc;
      b3_r    <= b3_calc;
      b4_r    <= b4_calc;
      total_r <= cnt_calc;
      pos_r   <= '0;
    end
    if (emit_en) begin
      pos_r <= pos_r + 7'd1;
    end
    out_char_r <= char_calc;
  end

  assign out_strobe   = out_strobe_r;
  assign out_char_out = out_char_r;
  assign out_is_last  = out_last_r;

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == BK_EMIT))
    else $error("character strobed outside the emit state");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_last_r) |=> !out_strobe_r)
    else $error("character follows the last one of an item without a gap");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_EMIT) |-> (pos_r < total_r))
    else $error("output position beyond the planned character count");

endmodule
